FILE: hdl/sps_pkg.sv
package sps_pkg;

  localparam int unsigned LastStep = 40;

  // Field kind codes from the syntax table.
  localparam logic [5:0] KindUe = 6'h10;
  localparam logic [5:0] KindSe = 6'h20;

  // Status codes carried with each result word.
  localparam logic [2:0] StElem     = 3'd0;
  localparam logic [2:0] StDone     = 3'd1;
  localparam logic [2:0] StVui      = 3'd2;
  localparam logic [2:0] StReserved = 3'd3;
  localparam logic [2:0] StOverlong = 3'd4;
  localparam logic [2:0] StTrail    = 3'd5;

  // Syntax steps that steer the parse.
  localparam logic [5:0] StepProfile  = 6'd0;
  localparam logic [5:0] StepReserved = 6'd7;
  localparam logic [5:0] StepSpsId    = 6'd9;
  localparam logic [5:0] StepChroma   = 6'd10;
  localparam logic [5:0] StepSeparate = 6'd11;
  localparam logic [5:0] StepDepth    = 6'd12;
  localparam logic [5:0] StepMatrix   = 6'd15;
  localparam logic [5:0] StepListFlag = 6'd16;
  localparam logic [5:0] StepDelta    = 6'd17;
  localparam logic [5:0] StepRun      = 6'd18;
  localparam logic [5:0] StepFrameNum = 6'd19;
  localparam logic [5:0] StepPocType  = 6'd20;
  localparam logic [5:0] StepPocLsb   = 6'd21;
  localparam logic [5:0] StepDeltaZero = 6'd22;
  localparam logic [5:0] StepCycle    = 6'd25;
  localparam logic [5:0] StepRefOfs   = 6'd26;
  localparam logic [5:0] StepMaxRef   = 6'd27;
  localparam logic [5:0] StepFrameMbs = 6'd31;
  localparam logic [5:0] StepMbaff    = 6'd32;
  localparam logic [5:0] StepDirect   = 6'd33;
  localparam logic [5:0] StepCrop     = 6'd34;
  localparam logic [5:0] StepCropLeft = 6'd35;
  localparam logic [5:0] StepVui      = 6'd39;
  localparam logic [5:0] StepStop     = 6'd40;

  typedef enum logic [1:0] {
    SIdle,
    SBits,
    SOut
  } state_e;

  function automatic logic [5:0] kind_of(input logic [5:0] s);
    logic [5:0] k;
    case (s)
      6'd0, 6'd8: k = 6'd8;
      6'd7: k = 6'd2;
      6'd9, 6'd10, 6'd12, 6'd13, 6'd19, 6'd20, 6'd21, 6'd25, 6'd27,
      6'd29, 6'd30, 6'd35, 6'd36, 6'd37, 6'd38: k = KindUe;
      6'd17, 6'd23, 6'd24, 6'd26: k = KindSe;
      default: k = 6'd1;
    endcase
    return k;
  endfunction

  function automatic logic high_profile(input logic [7:0] p);
    return p == 8'd100 || p == 8'd110 || p == 8'd122 || p == 8'd244 ||
           p == 8'd44 || p == 8'd83 || p == 8'd86 || p == 8'd118 ||
           p == 8'd128 || p == 8'd138 || p == 8'd139 || p == 8'd134 ||
           p == 8'd135;
  endfunction

endpackage

FILE: hdl/h264_sps_syntax_parser_core.sv
// Channel | Direction | Handshake           | Payload
// in      | input     | in_valid/in_stall   | byte_value, last_byte
// out     | output    | out_valid/out_stall | element_code .. last_result
// A byte is taken in the idle state, its eight bits are stepped through in order and
// a closing state ends the byte. A VUI-follows pair puts its second word in on a step
// of its own, an early end word is queued in the closing state ahead of the held word,
// and once the parse has stopped the bit steps are skipped. Each result word waits in
// a hold register until the next word or the close of the byte, so that the last flag
// can be set on it; the bit step holds while the output register is full and stalled.
// Reset puts the parser at the profile field. After the last byte it
// returns to that state for the next parameter set.
module h264_sps_syntax_parser_core
  import sps_pkg::*;
#(
  parameter int unsigned MAX_LEADING_ZEROS = 31,
  parameter int unsigned MAX_REF_CYCLE = 255
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         byte_value_i,
  input  logic               last_byte_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [5:0]         element_code_o,
  output logic signed [32:0] element_value_o,
  output logic [3:0]         list_number_o,
  output logic [7:0]         list_position_o,
  output logic               use_default_matrix_o,
  output logic [2:0]         status_o,
  output logic               last_result_o
);

  localparam logic [5:0] MaxZeros = 6'(MAX_LEADING_ZEROS);
  localparam logic [7:0] MaxCycle = 8'(MAX_REF_CYCLE);

  state_e state_q, state_d;
  logic [7:0]  byte_q, byte_d;
  logic        last_q, last_d;
  logic [2:0]  bit_q, bit_d;
  logic [5:0]  step_q, step_d;
  logic [3:0]  left_q, left_d;
  logic [5:0]  zeros_q, zeros_d;
  logic [31:0] acc_q, acc_d;
  logic [7:0]  prof_q, prof_d;
  logic [1:0]  chroma_q, chroma_d;
  logic        term_q, term_d;
  logic [3:0]  lnum_q, lnum_d;
  logic [7:0]  ecnt_q, ecnt_d;
  logic [7:0]  etot_q, etot_d;
  logic [7:0]  prev_q, prev_d;

  // Output register: the word offered on the out channel.
  logic        ov_q, ov_d;
  logic [5:0]  oc_q, oc_d;
  logic [32:0] oval_q, oval_d;
  logic [3:0]  on_q, on_d;
  logic [7:0]  op_q, op_d;
  logic        od_q, od_d;
  logic [2:0]  os_q, os_d;
  logic        ol_q, ol_d;
  // Hold register: the newest word, kept until the next one or the close of the byte.
  logic        sv_q, sv_d;
  logic [5:0]  sc_q, sc_d;
  logic [32:0] sval_q, sval_d;
  logic [3:0]  sn_q, sn_d;
  logic [7:0]  sp_q, sp_d;
  logic        sd_q, sd_d;
  logic [2:0]  ss_q, ss_d;
  // A VUI-follows word waits here behind the flag word.
  logic        p_q, p_d;

  logic        b;
  logic [5:0]  kind;
  logic [32:0] fval;
  logic        fin;
  logic [31:0] acc_sh;
  logic [7:0]  ns;
  logic        busy_out;

  assign b = byte_q[bit_q];
  assign kind = kind_of(step_q);
  assign acc_sh = {acc_q[30:0], b};
  assign busy_out = ov_q && out_stall_i;
  assign in_stall_o = (state_q != SIdle);
  assign out_valid_o = ov_q;
  assign element_code_o = oc_q;
  assign element_value_o = oval_q;
  assign list_number_o = on_q;
  assign list_position_o = op_q;
  assign use_default_matrix_o = od_q;
  assign status_o = os_q;
  assign last_result_o = ol_q;

  // Sequencer: one bit per cycle through the shared bit step, unless the output is stalled.
  always_comb begin
    logic [32:0] raw;
    logic [3:0]  limit;
    logic [5:0]  nx;
    logic [5:0]  knx;
    logic        put1;
    logic [5:0]  c1;
    logic [32:0] v1;
    logic [3:0]  n1;
    logic [7:0]  p1;
    logic        d1;
    logic [2:0]  s1;
    logic        put2;
    logic        do_enter;
    logic        done_bits;
    state_d = state_q; byte_d = byte_q; last_d = last_q; bit_d = bit_q;
    step_d = step_q; left_d = left_q; zeros_d = zeros_q; acc_d = acc_q;
    prof_d = prof_q; chroma_d = chroma_q; term_d = term_q; lnum_d = lnum_q;
    ecnt_d = ecnt_q; etot_d = etot_q; prev_d = prev_q;
    ov_d = ov_q && out_stall_i; oc_d = oc_q; oval_d = oval_q; on_d = on_q;
    op_d = op_q; od_d = od_q; os_d = os_q; ol_d = ol_q;
    sv_d = sv_q; sc_d = sc_q; sval_d = sval_q; sn_d = sn_q; sp_d = sp_q;
    sd_d = sd_q; ss_d = ss_q;
    p_d = p_q;
    raw = '0; limit = '0; nx = step_q + 6'd1; knx = '0; fin = 1'b0;
    put1 = 1'b0; c1 = step_q; v1 = '0; n1 = '0; p1 = '0; d1 = 1'b0; s1 = StElem;
    put2 = 1'b0; do_enter = 1'b0; done_bits = 1'b0;
    fval = '0; ns = '0;
    case (state_q)
      SIdle: begin
        if (in_valid_i) begin
          byte_d = byte_value_i; last_d = last_byte_i; bit_d = 3'd7;
          state_d = SBits;
        end
      end
      SBits: begin
        if (p_q) begin
          // The VUI-follows word goes in behind the flag word.
          if (!busy_out) begin
            put1 = 1'b1; c1 = StepVui; s1 = StVui; p_d = 1'b0;
          end
        end else if (!busy_out) begin
          if (!term_q) begin
            // Bit step: fixed field or Exp-Golomb.
            if (kind < KindUe) begin
              acc_d = acc_sh;
              if (left_q != 0) left_d = left_q - 4'd1;
              if (left_q <= 4'd1) begin fin = 1'b1; raw = {1'b0, acc_sh}; end
            end else if (acc_q == 0) begin
              if (!b) begin
                if (zeros_q >= MaxZeros) begin
                  put1 = 1'b1; s1 = StOverlong; term_d = 1'b1;
                end else zeros_d = zeros_q + 6'd1;
              end else begin
                acc_d = 32'd1;
                if (zeros_q == 0) begin fin = 1'b1; raw = '0; end
              end
            end else begin
              acc_d = acc_sh; zeros_d = zeros_q - 6'd1;
              if (zeros_q == 6'd1) begin fin = 1'b1; raw = {1'b0, acc_sh} - 33'd1; end
            end
            if (kind == KindSe)
              fval = raw[0] ? ((raw + 33'd1) >> 1) : (33'd0 - (raw >> 1));
            else fval = raw;
            ns = prev_q + fval[7:0];
            limit = (chroma_q == 2'd3) ? 4'd12 : 4'd8;
            if (fin) begin
              put1 = 1'b1; v1 = fval; do_enter = 1'b1;
              case (step_q)
                StepProfile: prof_d = fval[7:0];
                StepReserved: if (fval != 0) begin
                  s1 = StReserved; term_d = 1'b1; do_enter = 1'b0;
                end
                StepSpsId: nx = high_profile(prof_q) ? StepChroma : StepFrameNum;
                StepChroma: begin
                  chroma_d = (fval <= 33'd3) ? fval[1:0] : 2'd0;
                  nx = (fval == 33'd3) ? StepSeparate : StepDepth;
                end
                StepMatrix: if (fval != 0) begin
                  lnum_d = '0; nx = StepListFlag;
                end else nx = StepFrameNum;
                StepListFlag: begin
                  n1 = lnum_q;
                  if (fval != 0) begin
                    ecnt_d = '0; etot_d = (lnum_q < 4'd6) ? 8'd16 : 8'd64;
                    prev_d = 8'd8; nx = StepDelta;
                  end else begin
                    lnum_d = lnum_q + 4'd1;
                    nx = (lnum_q + 4'd1 >= limit) ? StepFrameNum : StepListFlag;
                  end
                end
                StepDelta: begin
                  n1 = lnum_q; p1 = ecnt_q;
                  if (ns == 0) begin
                    c1 = StepRun; v1 = {25'd0, prev_q}; d1 = (ecnt_q == 0);
                    lnum_d = lnum_q + 4'd1;
                    nx = (lnum_q + 4'd1 >= limit) ? StepFrameNum : StepListFlag;
                  end else begin
                    v1 = {25'd0, ns}; prev_d = ns; ecnt_d = ecnt_q + 8'd1;
                    if (ecnt_q + 8'd1 >= etot_q) begin
                      lnum_d = lnum_q + 4'd1;
                      nx = (lnum_q + 4'd1 >= limit) ? StepFrameNum : StepListFlag;
                    end else nx = StepDelta;
                  end
                end
                StepPocType: nx = (fval == 0) ? StepPocLsb :
                                  ((fval == 33'd1) ? StepDeltaZero : StepMaxRef);
                StepPocLsb: nx = StepMaxRef;
                StepCycle: begin
                  etot_d = (fval > {25'd0, MaxCycle}) ? MaxCycle : fval[7:0];
                  ecnt_d = '0;
                  nx = (fval != 0) ? StepRefOfs : StepMaxRef;
                end
                StepRefOfs: begin
                  n1 = ecnt_q[3:0]; p1 = ecnt_q; ecnt_d = ecnt_q + 8'd1;
                  nx = (ecnt_q + 8'd1 >= etot_q) ? StepMaxRef : StepRefOfs;
                end
                StepFrameMbs: nx = (fval != 0) ? StepDirect : StepMbaff;
                StepCrop: nx = (fval != 0) ? StepCropLeft : StepVui;
                StepVui: if (fval != 0) begin
                  put2 = 1'b1; term_d = 1'b1; do_enter = 1'b0;
                end
                StepStop: begin
                  v1 = '0; s1 = (fval != 0) ? StDone : StTrail;
                  term_d = 1'b1; do_enter = 1'b0;
                end
                default: ;
              endcase
              if (do_enter) begin
                knx = kind_of(nx);
                step_d = nx;
                left_d = (knx < KindUe) ? knx[3:0] : 4'd0;
                zeros_d = '0; acc_d = '0;
              end
            end
            if (put2) p_d = 1'b1;
          end
          if (bit_q == 0 || term_q) done_bits = 1'b1;
          else bit_d = bit_q - 3'd1;
          if (done_bits && !put2) state_d = SOut;
        end
      end
      SOut: begin
        // Close the byte: queue an early end word first, then send the held word as last.
        if (!busy_out) begin
          if (last_q && !term_q) begin
            put1 = 1'b1; s1 = StTrail; term_d = 1'b1;
          end else begin
            if (sv_q) begin
              ov_d = 1'b1; oc_d = sc_q; oval_d = sval_q; on_d = sn_q; op_d = sp_q;
              od_d = sd_q; os_d = ss_q; ol_d = 1'b1; sv_d = 1'b0;
            end
            if (last_q) begin
              step_d = StepProfile; left_d = 4'd8; zeros_d = '0; acc_d = '0;
              prof_d = '0; chroma_d = 2'd1; term_d = 1'b0; lnum_d = '0;
              ecnt_d = '0; etot_d = '0; prev_d = 8'd8;
            end
            state_d = SIdle;
          end
        end
      end
      default: state_d = SIdle;
    endcase
    // A new word moves the held one to the output register and takes its place.
    if (put1) begin
      if (sv_q) begin
        ov_d = 1'b1; oc_d = sc_q; oval_d = sval_q; on_d = sn_q; op_d = sp_q;
        od_d = sd_q; os_d = ss_q; ol_d = 1'b0;
      end
      sv_d = 1'b1; sc_d = c1; sval_d = v1; sn_d = n1; sp_d = p1; sd_d = d1; ss_d = s1;
    end
  end

  // Control and parse state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle; step_q <= StepProfile; left_q <= 4'd8; zeros_q <= '0;
      acc_q <= '0; prof_q <= '0; chroma_q <= 2'd1; term_q <= 1'b0;
      lnum_q <= '0; ecnt_q <= '0; etot_q <= '0; prev_q <= 8'd8;
      ov_q <= 1'b0; sv_q <= 1'b0; p_q <= 1'b0; bit_q <= '0; last_q <= 1'b0;
    end else begin
      state_q <= state_d; step_q <= step_d; left_q <= left_d; zeros_q <= zeros_d;
      acc_q <= acc_d; prof_q <= prof_d; chroma_q <= chroma_d; term_q <= term_d;
      lnum_q <= lnum_d; ecnt_q <= ecnt_d; etot_q <= etot_d; prev_q <= prev_d;
      ov_q <= ov_d; sv_q <= sv_d; p_q <= p_d; bit_q <= bit_d;
      last_q <= last_d;
    end
  end

  // Data registers of the byte and of both word registers.
  always_ff @(posedge clk_i) begin
    byte_q <= byte_d; oc_q <= oc_d; oval_q <= oval_d; on_q <= on_d;
    op_q <= op_d; od_q <= od_d; os_q <= os_d; ol_q <= ol_d;
    sc_q <= sc_d; sval_q <= sval_d; sn_q <= sn_d; sp_q <= sp_d;
    sd_q <= sd_d; ss_q <= ss_d;
  end

`ifndef SYNTHESIS
  // A pending second word only exists while bits are being processed.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    p_q |-> state_q == SBits) else $error("pending word outside bit phase");
  // No byte is taken while the parser is busy.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != SIdle |-> in_stall_o) else $error("accepted while busy");
  // Closing a last byte always leaves the parser at the profile field.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SOut && last_q && term_q && !busy_out) |=>
      step_q == StepProfile && !term_q)
    else $error("no return to reset after last byte");
  // A stalled result word stays valid and unchanged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o && $stable(element_code_o) &&
      $stable(element_value_o) && $stable(status_o) && $stable(last_result_o))
    else $error("stalled result word changed");
`endif

endmodule
